// ----- rtl/min_heap_priority_queue_unit_assert.svh -----
// Assertion macros used by the top level of the priority queue.
`ifndef MIN_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MHPQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("priority queue assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("priority queue assertion failed");

`endif

// ----- rtl/mhpq_pkg.sv -----
// Package with constants, codes and interface structs of the priority queue.
package mhpq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int KEY_W = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_OUT_W = 7;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    localparam logic [2:0] RD_ROOT = 3'd0;
    localparam logic [2:0] RD_LAST = 3'd1;
    localparam logic [2:0] RD_PARENT = 3'd2;
    localparam logic [2:0] RD_LEFT = 3'd3;
    localparam logic [2:0] RD_RIGHT = 3'd4;

    localparam logic [1:0] WR_KEY = 2'd0;
    localparam logic [1:0] WR_RD = 2'd1;
    localparam logic [1:0] WR_BV = 2'd2;

    typedef struct packed {
        logic                load_in;
        logic                ins_init;
        logic                ex_init;
        logic                cap_key;
        logic                set_status;
        logic [STATUS_W-1:0] status_code;
        logic                rd_en;
        logic [2:0]          rd_sel;
        logic                wr_en;
        logic [1:0]          wr_sel;
        logic                pick_left;
        logic                pick_right;
        logic                pos_up;
        logic                pos_best;
        logic                out_load;
    } cmd_t;

    typedef struct packed {
        logic op_extract;
        logic count_zero;
        logic count_full;
        logic pos_zero;
        logic l_out;
        logic r_in;
        logic rd_gt_key;
        logic best_is_pos;
    } sts_t;

endpackage

// ----- rtl/mhpq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/mhpq_dp.sv -----
// Datapath of the priority queue: heap memory, sift pointers, compares and result registers.
module mhpq_dp #(
    parameter int DEPTH = mhpq_pkg::DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mhpq_pkg::cmd_t                       cmd,
    output mhpq_pkg::sts_t                       sts,
    input  logic                                 op,
    input  logic signed [mhpq_pkg::KEY_W-1:0]    key_in,
    output logic signed [mhpq_pkg::KEY_W-1:0]    key_out,
    output logic [mhpq_pkg::STATUS_W-1:0]        status,
    output logic [mhpq_pkg::COUNT_OUT_W-1:0]     count_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = AW + 2;

    logic                              op_reg;
    logic signed [mhpq_pkg::KEY_W-1:0] key_reg;
    logic signed [mhpq_pkg::KEY_W-1:0] bv_reg;
    logic signed [mhpq_pkg::KEY_W-1:0] key_res_reg;
    logic [mhpq_pkg::STATUS_W-1:0]     status_res_reg;
    logic signed [mhpq_pkg::KEY_W-1:0] key_out_reg;
    logic [mhpq_pkg::STATUS_W-1:0]     status_out_reg;
    logic [mhpq_pkg::COUNT_OUT_W-1:0]  count_out_reg;
    logic [AW-1:0]                     pos_reg;
    logic [AW-1:0]                     best_reg;
    logic                              best_is_pos_reg;
    logic [CW-1:0]                     count_reg;

    logic [XW-1:0]                     l_x;
    logic [XW-1:0]                     r_x;
    logic [XW-1:0]                     count_x;
    logic [AW-1:0]                     parent;
    logic [AW-1:0]                     last;
    logic [AW-1:0]                     rd_addr;
    logic signed [mhpq_pkg::KEY_W-1:0] wr_data;
    logic signed [mhpq_pkg::KEY_W-1:0] rd_data;
    logic [mhpq_pkg::KEY_W-1:0]        rd_data_raw;

    assign l_x = XW'({pos_reg, 1'b1});
    assign r_x = l_x + XW'(1);
    assign count_x = XW'(count_reg);
    assign parent = (pos_reg - AW'(1)) >> 1;
    assign last = AW'(count_reg - CW'(1));
    assign rd_data = $signed(rd_data_raw);

    always_comb
    begin
        unique case (cmd.rd_sel)
            mhpq_pkg::RD_ROOT:   rd_addr = '0;
            mhpq_pkg::RD_LAST:   rd_addr = last;
            mhpq_pkg::RD_PARENT: rd_addr = parent;
            mhpq_pkg::RD_LEFT:   rd_addr = l_x[AW-1:0];
            mhpq_pkg::RD_RIGHT:  rd_addr = r_x[AW-1:0];
            default:             rd_addr = '0;
        endcase
    end

    always_comb
    begin
        unique case (cmd.wr_sel)
            mhpq_pkg::WR_KEY: wr_data = key_reg;
            mhpq_pkg::WR_RD:  wr_data = rd_data;
            mhpq_pkg::WR_BV:  wr_data = bv_reg;
            default:          wr_data = key_reg;
        endcase
    end

    mhpq_ram #(
        .WIDTH (mhpq_pkg::KEY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (pos_reg),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data_raw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.ins_init)
        begin
            count_reg <= count_reg + CW'(1);
        end
        else if (cmd.ex_init)
        begin
            count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg <= op;
            key_reg <= key_in;
            key_res_reg <= '0;
            status_res_reg <= mhpq_pkg::ST_OK;
        end
        if (cmd.set_status)
        begin
            status_res_reg <= cmd.status_code;
        end
        if (cmd.cap_key)
        begin
            key_res_reg <= rd_data;
        end
        if (cmd.ins_init)
        begin
            pos_reg <= AW'(count_reg);
        end
        if (cmd.ex_init)
        begin
            key_reg <= rd_data;
            pos_reg <= '0;
        end
        if (cmd.pos_up)
        begin
            pos_reg <= parent;
        end
        if (cmd.pos_best)
        begin
            pos_reg <= best_reg;
        end
        if (cmd.pick_left)
        begin
            if (key_reg > rd_data)
            begin
                best_reg <= l_x[AW-1:0];
                bv_reg <= rd_data;
                best_is_pos_reg <= 1'b0;
            end
            else
            begin
                best_reg <= pos_reg;
                bv_reg <= key_reg;
                best_is_pos_reg <= 1'b1;
            end
        end
        if (cmd.pick_right && (bv_reg > rd_data))
        begin
            best_reg <= r_x[AW-1:0];
            bv_reg <= rd_data;
            best_is_pos_reg <= 1'b0;
        end
        if (cmd.out_load)
        begin
            key_out_reg <= key_res_reg;
            status_out_reg <= status_res_reg;
            count_out_reg <= mhpq_pkg::COUNT_OUT_W'(count_reg);
        end
    end

    assign sts.op_extract = (op_reg == mhpq_pkg::OP_EXTRACT);
    assign sts.count_zero = (count_reg == '0);
    assign sts.count_full = (count_reg == CW'(DEPTH));
    assign sts.pos_zero = (pos_reg == '0);
    assign sts.l_out = (l_x >= count_x);
    assign sts.r_in = (r_x < count_x);
    assign sts.rd_gt_key = (rd_data > key_reg);
    assign sts.best_is_pos = best_is_pos_reg;

    assign key_out = key_out_reg;
    assign status = status_out_reg;
    assign count_out = count_out_reg;

endmodule

// ----- rtl/mhpq_ctrl.sv -----
// Controller state machine that sequences inserts, extracts and result transfers.
module mhpq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  mhpq_pkg::sts_t sts,
    output mhpq_pkg::cmd_t cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_EX_ROOT = 4'd2;
    localparam logic [3:0] S_EX_LAST = 4'd3;
    localparam logic [3:0] S_UP_CHK = 4'd4;
    localparam logic [3:0] S_UP_CMP = 4'd5;
    localparam logic [3:0] S_DN_CHK = 4'd6;
    localparam logic [3:0] S_DN_L = 4'd7;
    localparam logic [3:0] S_DN_R = 4'd8;
    localparam logic [3:0] S_DN_DEC = 4'd9;
    localparam logic [3:0] S_FIN = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (!sts.op_extract)
                begin
                    if (sts.count_full)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status_code = mhpq_pkg::ST_FULL;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.ins_init = 1'b1;
                        state_next = S_UP_CHK;
                    end
                end
                else if (sts.count_zero)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_code = mhpq_pkg::ST_EMPTY;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_sel = mhpq_pkg::RD_ROOT;
                    state_next = S_EX_ROOT;
                end
            end
            S_EX_ROOT:
            begin
                cmd.cap_key = 1'b1;
                cmd.rd_en = 1'b1;
                cmd.rd_sel = mhpq_pkg::RD_LAST;
                state_next = S_EX_LAST;
            end
            S_EX_LAST:
            begin
                cmd.ex_init = 1'b1;
                state_next = S_DN_CHK;
            end
            S_UP_CHK:
            begin
                if (sts.pos_zero)
                begin
                    cmd.wr_en = 1'b1;
                    cmd.wr_sel = mhpq_pkg::WR_KEY;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_sel = mhpq_pkg::RD_PARENT;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (sts.rd_gt_key)
                begin
                    cmd.wr_sel = mhpq_pkg::WR_RD;
                    cmd.pos_up = 1'b1;
                    state_next = S_UP_CHK;
                end
                else
                begin
                    cmd.wr_sel = mhpq_pkg::WR_KEY;
                    state_next = S_FIN;
                end
            end
            S_DN_CHK:
            begin
                if (sts.l_out)
                begin
                    cmd.wr_en = 1'b1;
                    cmd.wr_sel = mhpq_pkg::WR_KEY;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_sel = mhpq_pkg::RD_LEFT;
                    state_next = S_DN_L;
                end
            end
            S_DN_L:
            begin
                cmd.pick_left = 1'b1;
                if (sts.r_in)
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_sel = mhpq_pkg::RD_RIGHT;
                    state_next = S_DN_R;
                end
                else
                begin
                    state_next = S_DN_DEC;
                end
            end
            S_DN_R:
            begin
                cmd.pick_right = 1'b1;
                state_next = S_DN_DEC;
            end
            S_DN_DEC:
            begin
                cmd.wr_en = 1'b1;
                if (sts.best_is_pos)
                begin
                    cmd.wr_sel = mhpq_pkg::WR_KEY;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.wr_sel = mhpq_pkg::WR_BV;
                    cmd.pos_best = 1'b1;
                    state_next = S_DN_CHK;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/min_heap_priority_queue_unit.sv -----
// Top level of the binary min-heap priority queue.
//
// Channel   Handshake              Payload
// input     in_valid / in_ready    op, key_in
// output    out_valid / out_ready  key_out, status, count_out
//
// From its input transfer until in_ready returns, an insert moves its key up and an extract moves
// the last element down through the heap, by at most log2(DEPTH) levels, and a refused operation
// goes straight to its result. The single read port of the heap memory and its registered read
// data set how long each level takes.
// Reset clears the element count and the controller. A waiting result does not block the next
// input transfer, but that item holds in its last cycle until the waiting result is transferred.
`include "min_heap_priority_queue_unit_assert.svh"

module min_heap_priority_queue_unit #(
    parameter int DEPTH = mhpq_pkg::DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 op,
    input  logic signed [mhpq_pkg::KEY_W-1:0]    key_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [mhpq_pkg::KEY_W-1:0]    key_out,
    output logic [mhpq_pkg::STATUS_W-1:0]        status,
    output logic [mhpq_pkg::COUNT_OUT_W-1:0]     count_out
);

    localparam logic [mhpq_pkg::COUNT_OUT_W-1:0] FULL_COUNT = mhpq_pkg::COUNT_OUT_W'(DEPTH);

    mhpq_pkg::cmd_t cmd;
    mhpq_pkg::sts_t sts;
    logic           full_result;
    logic           empty_result;

    mhpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mhpq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .op        (op),
        .key_in    (key_in),
        .key_out   (key_out),
        .status    (status),
        .count_out (count_out)
    );

    assign full_result = out_valid && (status == mhpq_pkg::ST_FULL);
    assign empty_result = out_valid && (status == mhpq_pkg::ST_EMPTY);

    `MHPQ_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_valid && in_ready, !in_ready)
    `MHPQ_ASSERT_SAME(a_full_count, clk, rst_n, full_result, (count_out == FULL_COUNT) && (key_out == '0))
    `MHPQ_ASSERT_SAME(a_empty_result, clk, rst_n, empty_result, (count_out == '0) && (key_out == '0))

endmodule
